// ===== sv/brmq_pkg.sv =====
// Shared constants, codes and types of the byte ring message queue.
package brmq_pkg;

	localparam int DEPTH    = 1024;
	localparam int MAX_READ = 64;
	localparam int PTR_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int CAP_W    = 11;
	localparam int LEN_W    = 7;
	localparam int MSG_W    = 11;
	localparam int BYTE_W   = 8;
	localparam int DIV_W    = $clog2(DEPTH + MAX_READ);
	localparam int BIT_W    = $clog2(DIV_W);
	localparam int S_DATA_W = 40;
	localparam int S_USER_W = 4;
	localparam int M_DATA_W = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

	typedef enum logic [2:0] {
		CMD_CLEAR = 3'd0,
		CMD_PUSH  = 3'd1,
		CMD_FRONT = 3'd2,
		CMD_POP   = 3'd3,
		CMD_SET   = 3'd4,
		CMD_GET   = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NOSPACE = 3'd1,
		ST_TOOBIG  = 3'd2,
		ST_NOPEND  = 3'd3,
		ST_RANGE   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_CLEAR,
		S_FRD,
		S_FEMIT,
		S_MOD,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [PTR_W-1:0]  addr;
		logic [BYTE_W-1:0] wdata;
	} mem_req_t;

endpackage

// ===== sv/brmq_store.sv =====
// Byte store of the ring: one port, registered read data.
module brmq_store (
	input  logic                       clk,
	input  brmq_pkg::mem_req_t         req,
	output logic [brmq_pkg::BYTE_W-1:0] rdata
);

	logic [brmq_pkg::BYTE_W-1:0] mem [brmq_pkg::DEPTH];
	logic [brmq_pkg::BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/brmq_cmpsub.sv =====
// Shared compare-and-subtract unit against the ring capacity.
module brmq_cmpsub (
	input  logic [brmq_pkg::CNT_W:0]   x,
	input  logic [brmq_pkg::CAP_W-1:0] cap,
	output logic                       ge,
	output logic [brmq_pkg::CNT_W:0]   diff
);

	logic [brmq_pkg::CNT_W:0] cap_w;

	assign cap_w = (brmq_pkg::CNT_W + 1)'(cap);
	assign ge    = x >= cap_w;
	assign diff  = x - cap_w;

endmodule

// ===== sv/byte_ring_message_queue.sv =====
// Top level of the byte ring message queue: sequencer, state and result register.
//
// A byte ring of up to 1024 slots, of which the first "capacity" are in use
// (values below 2 act as 2, above 1024 as 1024; reset value 1024). Free space
// is capacity - 1 - used. Commands arrive one per transfer on the s_ side;
// every command gives one result transfer on the m_ side, except a successful
// front of N >= 1 bytes, which gives N transfers, the final one with tlast.
// One command is worked at a time, and s_tready is high only while idle.
// Push, set byte, get byte, rejected commands and unknown codes go from S_EXEC
// to S_EMIT, which loads the output register; pop first reduces the new head
// modulo capacity in S_MOD, one remainder bit per cycle through the shared
// compare-and-subtract unit; front alternates S_FRD and S_FEMIT per byte on
// the single byte-wide store port and its registered read; clear zeroes the
// store in S_CLEAR, one slot per cycle. After reset the store is swept to
// zero the same way, during which no command is accepted (capacity writes
// are taken at any time). A result waiting in the output register does not
// hold off the next command; only a new result waits for it to drain.
module byte_ring_message_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// data[7:0], msg_len[18:8], read_len[25:19], pos[35:26], zero[39:36]
	input  logic [brmq_pkg::S_DATA_W-1:0]   s_tdata,
	// cmd[2:0], first[3]
	input  logic [brmq_pkg::S_USER_W-1:0]   s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// status[2:0], byte_out[10:3], used[21:11], free_space[31:22]
	output logic [brmq_pkg::M_DATA_W-1:0]   m_tdata,
	output logic                            m_tlast,
	input  logic                            cfg_wen,
	input  logic [brmq_pkg::CAP_W-1:0]      cfg_wdata
);

	localparam logic [brmq_pkg::PTR_W-1:0] LAST_ADDR = brmq_pkg::PTR_W'(brmq_pkg::DEPTH - 1);

	brmq_pkg::state_t state_q, state_d;

	// Configuration and queue state
	logic [brmq_pkg::CAP_W-1:0]  cap_q;
	logic [brmq_pkg::PTR_W-1:0]  head_q, tail_q;
	logic [brmq_pkg::CNT_W-1:0]  used_q;
	logic [brmq_pkg::LEN_W-1:0]  pend_q;
	logic                        rej_q;

	// Sequencer working registers
	logic [brmq_pkg::PTR_W-1:0]  clr_addr_q;
	logic [brmq_pkg::PTR_W-1:0]  p_q;
	logic [brmq_pkg::LEN_W-1:0]  left_q;
	logic [brmq_pkg::CNT_W-1:0]  r_q;
	logic [brmq_pkg::DIV_W-1:0]  div_q;
	logic [brmq_pkg::BIT_W-1:0]  bit_q;
	brmq_pkg::status_t           res_status_q;
	logic                        use_rd_q;

	// Latched command
	logic [2:0]                  cmd_q;
	logic [brmq_pkg::BYTE_W-1:0] data_q;
	logic                        first_q;
	logic [brmq_pkg::MSG_W-1:0]  msg_len_q;
	logic [brmq_pkg::LEN_W-1:0]  read_len_q;
	logic [brmq_pkg::PTR_W-1:0]  pos_q;

	// Result register
	logic                          m_tvalid_q;
	logic [brmq_pkg::M_DATA_W-1:0] m_tdata_q;
	logic                          m_tlast_q;

	// Derived values
	logic [brmq_pkg::CAP_W-1:0]  cap_eff;
	logic [brmq_pkg::CAP_W-1:0]  cap_m1;
	logic [brmq_pkg::CNT_W-1:0]  free_cnt;
	logic                        out_free;
	logic                        push_rej_new;
	logic                        push_ok;
	logic                        front_bad;
	logic                        set_ok;
	logic                        get_ok;
	logic [brmq_pkg::CNT_W-1:0]  pos_ext;

	// Shared unit and store
	logic [brmq_pkg::CNT_W:0]    alu_x;
	logic                        alu_ge;
	logic [brmq_pkg::CNT_W:0]    alu_diff;
	logic [brmq_pkg::PTR_W-1:0]  step_ptr;
	logic [brmq_pkg::CNT_W-1:0]  r_next;
	brmq_pkg::mem_req_t          mem_req;
	logic [brmq_pkg::BYTE_W-1:0] rdata;

	// Result load controls
	logic                        out_load;
	brmq_pkg::status_t           out_status;
	logic [brmq_pkg::BYTE_W-1:0] out_byte;
	logic                        out_last;

	logic                        s_accept;

	brmq_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	brmq_cmpsub u_cmpsub (
		.x    (alu_x),
		.cap  (cap_eff),
		.ge   (alu_ge),
		.diff (alu_diff)
	);

	// Clamp capacity into the supported range
	always_comb begin
		if (cap_q < brmq_pkg::CAP_W'(2)) begin
			cap_eff = brmq_pkg::CAP_W'(2);
		end else if (cap_q > brmq_pkg::CAP_W'(brmq_pkg::DEPTH)) begin
			cap_eff = brmq_pkg::CAP_W'(brmq_pkg::DEPTH);
		end else begin
			cap_eff = cap_q;
		end
	end

	assign cap_m1   = cap_eff - brmq_pkg::CAP_W'(1);
	// Free space saturates at zero when capacity shrank under stored data
	assign free_cnt = (used_q >= brmq_pkg::CNT_W'(cap_m1)) ? '0
	                : brmq_pkg::CNT_W'(cap_m1) - used_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign s_accept = s_tvalid && s_tready;
	assign pos_ext  = brmq_pkg::CNT_W'(pos_q);

	// A first byte re-arms or rejects the whole message
	assign push_rej_new = first_q ? (brmq_pkg::CNT_W'(msg_len_q) > free_cnt) : rej_q;
	assign push_ok      = !push_rej_new && (free_cnt != '0);
	assign front_bad    = (read_len_q > brmq_pkg::LEN_W'(brmq_pkg::MAX_READ))
	                   || (brmq_pkg::CNT_W'(read_len_q) > used_q);
	// The last slot of the ring cannot be set
	assign set_ok       = (pos_ext + brmq_pkg::CNT_W'(1)) < brmq_pkg::CNT_W'(cap_eff);
	assign get_ok       = pos_ext < brmq_pkg::CNT_W'(cap_eff);

	// Shared unit: pointer step with wrap, or one restoring remainder bit
	always_comb begin
		unique case (state_q)
			brmq_pkg::S_MOD:   alu_x = {r_q, div_q[bit_q]};
			brmq_pkg::S_FEMIT: alu_x = (brmq_pkg::CNT_W + 1)'(p_q) + (brmq_pkg::CNT_W + 1)'(1);
			default:           alu_x = (brmq_pkg::CNT_W + 1)'(tail_q) + (brmq_pkg::CNT_W + 1)'(1);
		endcase
	end

	assign step_ptr = alu_ge ? '0 : alu_x[brmq_pkg::PTR_W-1:0];
	assign r_next   = alu_ge ? alu_diff[brmq_pkg::CNT_W-1:0] : alu_x[brmq_pkg::CNT_W-1:0];

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			brmq_pkg::S_INIT: begin
				if (clr_addr_q == LAST_ADDR) begin
					state_d = brmq_pkg::S_IDLE;
				end
			end
			brmq_pkg::S_IDLE: begin
				if (s_tvalid) begin
					state_d = brmq_pkg::S_EXEC;
				end
			end
			brmq_pkg::S_EXEC: begin
				unique case (cmd_q)
					brmq_pkg::CMD_CLEAR: state_d = brmq_pkg::S_CLEAR;
					brmq_pkg::CMD_FRONT: begin
						if (!front_bad && (read_len_q != '0)) begin
							state_d = brmq_pkg::S_FRD;
						end else begin
							state_d = brmq_pkg::S_EMIT;
						end
					end
					brmq_pkg::CMD_POP: begin
						if (pend_q != '0) begin
							state_d = brmq_pkg::S_MOD;
						end else begin
							state_d = brmq_pkg::S_EMIT;
						end
					end
					default: state_d = brmq_pkg::S_EMIT;
				endcase
			end
			brmq_pkg::S_CLEAR: begin
				if (clr_addr_q == LAST_ADDR) begin
					state_d = brmq_pkg::S_EMIT;
				end
			end
			brmq_pkg::S_FRD: state_d = brmq_pkg::S_FEMIT;
			brmq_pkg::S_FEMIT: begin
				if (out_free) begin
					if (left_q == brmq_pkg::LEN_W'(1)) begin
						state_d = brmq_pkg::S_IDLE;
					end else begin
						state_d = brmq_pkg::S_FRD;
					end
				end
			end
			brmq_pkg::S_MOD: begin
				if (bit_q == '0) begin
					state_d = brmq_pkg::S_EMIT;
				end
			end
			brmq_pkg::S_EMIT: begin
				if (out_free) begin
					state_d = brmq_pkg::S_IDLE;
				end
			end
			default: state_d = brmq_pkg::S_IDLE;
		endcase
	end

	// Outputs of the sequencer: store port, handshake, result load
	always_comb begin
		mem_req    = '0;
		s_tready   = 1'b0;
		out_load   = 1'b0;
		out_status = brmq_pkg::ST_OK;
		out_byte   = '0;
		out_last   = 1'b1;
		unique case (state_q) inside
			brmq_pkg::S_INIT, brmq_pkg::S_CLEAR: begin
				mem_req.we   = 1'b1;
				mem_req.addr = clr_addr_q;
			end
			brmq_pkg::S_IDLE: s_tready = 1'b1;
			brmq_pkg::S_EXEC: begin
				unique case (cmd_q)
					brmq_pkg::CMD_PUSH: begin
						mem_req.we    = push_ok;
						mem_req.addr  = tail_q;
						mem_req.wdata = data_q;
					end
					brmq_pkg::CMD_SET: begin
						mem_req.we    = set_ok;
						mem_req.addr  = pos_q;
						mem_req.wdata = data_q;
					end
					brmq_pkg::CMD_GET: begin
						mem_req.re    = get_ok;
						mem_req.addr  = pos_q;
					end
					default: ;
				endcase
			end
			brmq_pkg::S_FRD: begin
				mem_req.re   = 1'b1;
				mem_req.addr = p_q;
			end
			brmq_pkg::S_FEMIT: begin
				out_load = out_free;
				out_byte = rdata;
				out_last = left_q == brmq_pkg::LEN_W'(1);
			end
			brmq_pkg::S_EMIT: begin
				out_load   = out_free;
				out_status = res_status_q;
				out_byte   = use_rd_q ? rdata : '0;
			end
			default: ;
		endcase
	end

	// Sequencer and queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= brmq_pkg::S_INIT;
			cap_q        <= brmq_pkg::CAP_RESET;
			head_q       <= '0;
			tail_q       <= '0;
			used_q       <= '0;
			pend_q       <= '0;
			rej_q        <= 1'b0;
			clr_addr_q   <= '0;
			p_q          <= '0;
			left_q       <= '0;
			r_q          <= '0;
			div_q        <= '0;
			bit_q        <= '0;
			res_status_q <= brmq_pkg::ST_OK;
			use_rd_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen) begin
				cap_q <= cfg_wdata;
			end
			unique case (state_q) inside
				brmq_pkg::S_INIT, brmq_pkg::S_CLEAR: begin
					clr_addr_q <= clr_addr_q + brmq_pkg::PTR_W'(1);
				end
				brmq_pkg::S_EXEC: begin
					use_rd_q     <= 1'b0;
					res_status_q <= brmq_pkg::ST_OK;
					unique case (cmd_q)
						brmq_pkg::CMD_CLEAR: begin
							head_q     <= '0;
							tail_q     <= '0;
							used_q     <= '0;
							pend_q     <= '0;
							rej_q      <= 1'b0;
							clr_addr_q <= '0;
						end
						brmq_pkg::CMD_PUSH: begin
							rej_q <= push_rej_new;
							if (push_ok) begin
								tail_q <= step_ptr;
								used_q <= used_q + brmq_pkg::CNT_W'(1);
							end else begin
								res_status_q <= brmq_pkg::ST_NOSPACE;
							end
						end
						brmq_pkg::CMD_FRONT: begin
							if (front_bad) begin
								res_status_q <= brmq_pkg::ST_TOOBIG;
							end else begin
								pend_q <= read_len_q;
								p_q    <= head_q;
								left_q <= read_len_q;
							end
						end
						brmq_pkg::CMD_POP: begin
							if (pend_q == '0) begin
								res_status_q <= brmq_pkg::ST_NOPEND;
							end else begin
								used_q <= (used_q >= brmq_pkg::CNT_W'(pend_q))
								        ? used_q - brmq_pkg::CNT_W'(pend_q) : '0;
								pend_q <= '0;
								// Head advance is reduced modulo capacity in S_MOD
								div_q  <= brmq_pkg::DIV_W'(head_q) + brmq_pkg::DIV_W'(pend_q);
								r_q    <= '0;
								bit_q  <= brmq_pkg::BIT_W'(brmq_pkg::DIV_W - 1);
							end
						end
						brmq_pkg::CMD_SET: begin
							if (!set_ok) begin
								res_status_q <= brmq_pkg::ST_RANGE;
							end
						end
						brmq_pkg::CMD_GET: begin
							use_rd_q <= get_ok;
							if (!get_ok) begin
								res_status_q <= brmq_pkg::ST_RANGE;
							end
						end
						default: ;
					endcase
				end
				brmq_pkg::S_FEMIT: begin
					if (out_free) begin
						p_q    <= step_ptr;
						left_q <= left_q - brmq_pkg::LEN_W'(1);
					end
				end
				brmq_pkg::S_MOD: begin
					r_q   <= r_next;
					bit_q <= bit_q - brmq_pkg::BIT_W'(1);
					if (bit_q == '0) begin
						head_q <= r_next[brmq_pkg::PTR_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	// Hold the accepted command's fields
	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_q      <= s_tuser[2:0];
			first_q    <= s_tuser[3];
			data_q     <= s_tdata[7:0];
			msg_len_q  <= s_tdata[18:8];
			read_len_q <= s_tdata[25:19];
			pos_q      <= s_tdata[35:26];
		end
	end

	// Result register: load a new result when the slot is empty or draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {free_cnt[brmq_pkg::PTR_W-1:0], used_q, out_byte, out_status};
			m_tlast_q <= out_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ===== sv/brmq_checker.sv =====
// Port-level checks of the byte ring message queue, bound to the top level.
module brmq_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [brmq_pkg::S_DATA_W-1:0]   s_tdata,
	input logic [brmq_pkg::S_USER_W-1:0]   s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [brmq_pkg::M_DATA_W-1:0]   m_tdata,
	input logic                            m_tlast,
	input logic                            cfg_wen,
	input logic [brmq_pkg::CAP_W-1:0]      cfg_wdata
);

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// One command at a time: no transfer right after an accepted one
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready while a command is in progress");

	// A failed command's result is marked last
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] != brmq_pkg::ST_OK) |-> m_tlast)
		else $error("error result not marked last");

	// Used plus free never exceeds the largest ring less one slot while free is nonzero
	a_space: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[31:22] != '0)
		|-> ({1'b0, m_tdata[21:11]} + {2'b00, m_tdata[31:22]})
		    <= 12'(brmq_pkg::DEPTH - 1))
		else $error("used and free space inconsistent");

endmodule

bind byte_ring_message_queue brmq_checker u_brmq_checker (.*);
